// ----- hdl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg: shared types, constants and helpers of the frame allocator
// Sizes of the frame window and bitmap, request codes, search unit structs
// and small bit-scan functions.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // window geometry
    localparam int FRAME_BITS     = 16;
    localparam int NUM_FRAMES     = 1 << FRAME_BITS;
    localparam int WORD_IDX_BITS  = 6;
    localparam int WORD_BITS      = 1 << WORD_IDX_BITS;
    localparam int MAP_ADDR_BITS  = FRAME_BITS - WORD_IDX_BITS;
    localparam int MAP_WORDS      = 1 << MAP_ADDR_BITS;
    localparam int PAGE_SHIFT     = 12;
    localparam int PAGE_BYTES     = 1 << PAGE_SHIFT;
    localparam int WIN_BITS       = FRAME_BITS + PAGE_SHIFT;
    localparam int WINDOW_BYTES   = 1 << WIN_BITS;

    // field widths
    localparam int REQ_BITS       = 2;
    localparam int ADDR_BITS      = 40;
    localparam int CNT_BITS       = FRAME_BITS + 1;
    localparam int FRN_BITS       = ADDR_BITS - PAGE_SHIFT;
    localparam int LG_BITS        = $clog2(WORD_IDX_BITS + 1);

    // request codes
    localparam logic [REQ_BITS-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_FREE    = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_RELEASE = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_RESERVE = 2'd3;

    // status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_RUN = 1'b1;

    typedef logic [REQ_BITS-1:0]      t_req;
    typedef logic [ADDR_BITS-1:0]     t_addr;
    typedef logic [CNT_BITS-1:0]      t_cnt;
    typedef logic [FRAME_BITS-1:0]    t_frame;
    typedef logic [WIN_BITS-1:0]      t_res_addr;
    typedef logic [WORD_BITS-1:0]     t_word;
    typedef logic [MAP_ADDR_BITS-1:0] t_waddr;
    typedef logic [WORD_IDX_BITS:0]   t_bitcnt;

    // per-request setup of the first-fit search
    typedef struct packed {
        t_cnt                     want;       // frames wanted, at least one
        logic                     fits_word;  // run fits inside one word
        logic [LG_BITS-1:0]       lg;         // floor(log2(want)) for short runs
        logic [WORD_IDX_BITS-1:0] shift;      // want - 2**lg
    } t_srch_cfg;

    // per-word outcome of the search
    typedef struct packed {
        logic   hit;
        t_frame start;
        t_cnt   run_next;
    } t_srch_res;

    // index of lowest set bit, WORD_BITS when none
    function automatic t_bitcnt low_index(input t_word v);
        t_bitcnt idx;
        idx = t_bitcnt'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) idx = t_bitcnt'(i);
        end
        return idx;
    endfunction

    // index of highest set bit, zero when none
    function automatic logic [WORD_IDX_BITS-1:0] high_index(input t_word v);
        logic [WORD_IDX_BITS-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) idx = WORD_IDX_BITS'(i);
        end
        return idx;
    endfunction

    // number of set bits in a word
    function automatic t_bitcnt pop_count(input t_word v);
        t_bitcnt n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            n = n + t_bitcnt'(v[i]);
        end
        return n;
    endfunction

    // floor(log2(v)) for v in 1..WORD_BITS
    function automatic logic [LG_BITS-1:0] floor_log2(input t_bitcnt v);
        logic [LG_BITS-1:0] r;
        r = '0;
        for (int i = 0; i <= WORD_IDX_BITS; i++) begin
            if (v[i]) r = LG_BITS'(i);
        end
        return r;
    endfunction

endpackage

// ----- hdl/bfa_ram.sv -----
// ----------------------------------------------------------------------------
// bfa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- hdl/bfa_search_unit.sv -----
// ----------------------------------------------------------------------------
// bfa_search_unit: first-fit evaluation of one bitmap word
// Given the free run carried in from lower words, finds the earliest point in
// this word where a run of the wanted length completes, and the run carried
// out when it does not.
// ----------------------------------------------------------------------------
module bfa_search_unit (
    input  bfa_pkg::t_word     i_word,
    input  bfa_pkg::t_waddr    i_widx,
    input  bfa_pkg::t_cnt      i_run,
    input  bfa_pkg::t_srch_cfg i_cfg,
    output bfa_pkg::t_srch_res o_res
);
    import bfa_pkg::*;

    // g_lvl[k][i]: frames i-2**k+1 .. i of this word all free
    t_word g_lvl [0:WORD_IDX_BITS];
    t_word g_sel;
    t_word m_hit;

    t_bitcnt low_free;     // free frames from bit 0 up
    t_bitcnt top_free;     // free frames from the top bit down
    t_cnt    need;
    logic    hit_carry;
    logic    hit_inner;
    t_bitcnt pos;
    t_cnt    start_carry;
    t_cnt    start_inner;

    always_comb begin
        g_lvl[0] = ~i_word;
        for (int k = 1; k <= WORD_IDX_BITS; k++) begin
            g_lvl[k] = g_lvl[k-1] & (g_lvl[k-1] << (1 << (k - 1)));
        end
    end

    // window of want frames = two overlapping power-of-two windows
    assign g_sel = g_lvl[i_cfg.lg];
    assign m_hit = g_sel & (g_sel << i_cfg.shift);

    assign low_free = low_index(i_word);
    assign top_free = (i_word == '0) ? t_bitcnt'(WORD_BITS)
                    : t_bitcnt'(WORD_BITS - 1) - {1'b0, high_index(i_word)};

    // run that continues from lower words completes first when it can
    assign need        = i_cfg.want - i_run;
    assign hit_carry   = (need != '0) && (need <= t_cnt'(low_free));
    assign start_carry = {1'b0, i_widx, WORD_IDX_BITS'(0)} - i_run;

    // run that starts after a reserved frame inside this word
    assign pos         = low_index(m_hit);
    assign hit_inner   = i_cfg.fits_word && (m_hit != '0);
    assign start_inner = {1'b0, i_widx, pos[WORD_IDX_BITS-1:0]} + t_cnt'(1) - i_cfg.want;

    always_comb begin
        o_res.hit      = hit_carry || hit_inner;
        o_res.start    = hit_carry ? start_carry[FRAME_BITS-1:0]
                                   : start_inner[FRAME_BITS-1:0];
        o_res.run_next = (i_word == '0) ? i_run + t_cnt'(WORD_BITS)
                                        : t_cnt'(top_free);
    end

endmodule

// ----- hdl/bitmap_frame_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top: first-fit bitmap page frame allocator
// Keeps one reserved bit per 4 KiB frame over a 256 MiB window, with an exact
// free count, and serves alloc, free, release-range and reserve-range requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_valid/o_ready carries req_type, base_addr, length and
//   frame_count; each request gives exactly one result on o_valid/i_ready
//   (status, result_addr, free_count). Requests are served one at a time.
//   The bitmap is a 1024 x 64 RAM; one word is read and evaluated per cycle.
//   Alloc sets up, then scans words from word 0 up to the word where the run
//   completes (at most all 1024 words), then does a read-modify-write sweep
//   over the words the run covers. Free, release and reserve set up, then
//   sweep every word of the clamped range; an empty range skips the sweep.
//   After reset the block writes all ones into every word of the
//   bitmap (every frame reserved, free count 0) with o_ready low.
//   o_ready is high only while no request is in progress. A finished result
//   sits in an output register; a new request may be taken while it waits,
//   and that request only holds its own result back until the receiver takes
//   the previous one.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bfa_pkg::t_req      i_req_type,
    input  bfa_pkg::t_addr     i_base_addr,
    input  bfa_pkg::t_addr     i_length,
    input  bfa_pkg::t_cnt      i_frame_count,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_status,
    output bfa_pkg::t_res_addr o_result_addr,
    output bfa_pkg::t_cnt      o_free_count
);
    import bfa_pkg::*;

    // sequencer states
    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_SRCH  = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam t_waddr LAST_WORD = MAP_ADDR_BITS'(MAP_WORDS - 1);

    // control registers
    logic [2:0] r_state, n_state;
    t_waddr     r_clr, n_clr;
    logic       r_iss, n_iss;      // read issue active
    logic       r_dv, n_dv;        // read data valid
    logic       r_cv, n_cv;        // change mask valid
    logic       r_ov, n_ov;        // result waiting
    t_cnt       r_free, n_free;

    // payload registers
    t_req       r_type, n_type;
    t_addr      r_base, n_base;
    t_addr      r_len, n_len;
    t_cnt       r_fcnt, n_fcnt;
    t_waddr     r_cnt, n_cnt;      // word being read
    t_waddr     r_dw, n_dw;        // word whose data is out of the RAM
    t_cnt       r_lo, n_lo;        // frame range [lo, hi)
    t_cnt       r_hi, n_hi;
    logic       r_set, n_set;
    t_cnt       r_run, n_run;
    t_srch_cfg  r_cfg, n_cfg;
    t_word      r_chg, n_chg;
    logic       r_status, n_status;
    t_res_addr  r_res_addr, n_res_addr;
    logic       r_o_status;
    t_res_addr  r_o_addr;
    t_cnt       r_o_free;

    logic       load;

    // RAM ports
    logic       ram_we;
    t_waddr     ram_waddr;
    t_word      ram_wdata;
    t_word      ram_rdata;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt),
        .o_rdata (ram_rdata)
    );

    // shared word search unit
    t_srch_res srch_res;

    bfa_search_unit u_search (
        .i_word (ram_rdata),
        .i_widx (r_dw),
        .i_run  (r_run),
        .i_cfg  (r_cfg),
        .o_res  (srch_res)
    );

    // request setup: frame range for free/release/reserve, search setup for alloc
    logic [FRN_BITS-1:0]  fr;
    logic [FRN_BITS:0]    fr_end;
    logic [ADDR_BITS:0]   b_end;
    logic [WIN_BITS:0]    end_c;
    logic [WIN_BITS:0]    first_sum;
    t_cnt                 setup_lo;
    t_cnt                 setup_hi;
    logic                 setup_in;
    logic                 setup_ok;
    t_cnt                 want;
    t_srch_cfg            setup_cfg;

    always_comb begin
        fr        = r_base[ADDR_BITS-1:PAGE_SHIFT];
        fr_end    = {1'b0, fr} + (FRN_BITS + 1)'(r_fcnt);
        b_end     = {1'b0, r_base} + {1'b0, r_len};
        end_c     = (b_end > (ADDR_BITS + 1)'(WINDOW_BYTES))
                  ? (WIN_BITS + 1)'(WINDOW_BYTES) : b_end[WIN_BITS:0];
        first_sum = {1'b0, r_base[WIN_BITS-1:0]} + (WIN_BITS + 1)'(PAGE_BYTES - 1);
        if (r_type == REQ_FREE) begin
            setup_in = (fr >> FRAME_BITS) == '0;
            setup_lo = fr[CNT_BITS-1:0];
            setup_hi = (fr_end > (FRN_BITS + 1)'(NUM_FRAMES))
                     ? t_cnt'(NUM_FRAMES) : fr_end[CNT_BITS-1:0];
        end else begin
            // round start up and end down to whole frames
            setup_in = (r_base >> WIN_BITS) == '0;
            setup_lo = first_sum[WIN_BITS:PAGE_SHIFT];
            setup_hi = end_c[WIN_BITS:PAGE_SHIFT];
        end
        setup_ok = setup_in && (setup_hi > setup_lo);

        want                = (r_fcnt == '0) ? t_cnt'(1) : r_fcnt;
        setup_cfg.want      = want;
        setup_cfg.fits_word = want <= t_cnt'(WORD_BITS);
        setup_cfg.lg        = floor_log2(want[WORD_IDX_BITS:0]);
        setup_cfg.shift     = WORD_IDX_BITS'(want - (t_cnt'(1) << setup_cfg.lg));
    end

    // apply sweep: mask of frames in [lo, hi) within the current word
    t_cnt   hl;
    t_waddr lo_w;
    t_waddr last_w;
    t_word  lo_mask;
    t_word  hi_mask;
    t_word  mask;
    t_word  apply_new;
    t_word  apply_chg;

    always_comb begin
        hl        = r_hi - t_cnt'(1);
        lo_w      = r_lo[FRAME_BITS-1:WORD_IDX_BITS];
        last_w    = hl[FRAME_BITS-1:WORD_IDX_BITS];
        lo_mask   = (r_dw == lo_w) ? ({WORD_BITS{1'b1}} << r_lo[WORD_IDX_BITS-1:0])
                                   : {WORD_BITS{1'b1}};
        hi_mask   = (r_dw == last_w)
                  ? ({WORD_BITS{1'b1}} >> (WORD_IDX_BITS'(WORD_BITS - 1)
                                           - hl[WORD_IDX_BITS-1:0]))
                  : {WORD_BITS{1'b1}};
        mask      = lo_mask & hi_mask;
        apply_new = r_set ? (ram_rdata | mask) : (ram_rdata & ~mask);
        apply_chg = r_set ? (~ram_rdata & mask) : (ram_rdata & mask);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_iss      = r_iss;
        n_dv       = 1'b0;
        n_cv       = 1'b0;
        n_free     = r_free;
        n_type     = r_type;
        n_base     = r_base;
        n_len      = r_len;
        n_fcnt     = r_fcnt;
        n_cnt      = r_cnt;
        n_dw       = r_dw;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_set      = r_set;
        n_run      = r_run;
        n_cfg      = r_cfg;
        n_chg      = r_chg;
        n_status   = r_status;
        n_res_addr = r_res_addr;
        load       = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_dw;
        ram_wdata  = apply_new;

        case (r_state)
            S_CLR: begin
                // fill the bitmap with ones: every frame reserved
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = {WORD_BITS{1'b1}};
                n_clr     = r_clr + t_waddr'(1);
                if (r_clr == LAST_WORD) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_type  = i_req_type;
                    n_base  = i_base_addr;
                    n_len   = i_length;
                    n_fcnt  = i_frame_count;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_status   = STATUS_OK;
                n_res_addr = '0;
                n_run      = '0;
                n_cfg      = setup_cfg;
                if (r_type == REQ_ALLOC) begin
                    n_cnt   = '0;
                    n_iss   = 1'b1;
                    n_state = S_SRCH;
                end else begin
                    n_lo  = setup_lo;
                    n_hi  = setup_hi;
                    n_set = (r_type == REQ_RESERVE);
                    if (setup_ok) begin
                        n_cnt   = setup_lo[FRAME_BITS-1:WORD_IDX_BITS];
                        n_iss   = 1'b1;
                        n_state = S_APPLY;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SRCH: begin
                // stream words through the search unit
                n_dv = r_iss;
                n_dw = r_cnt;
                if (r_iss) begin
                    n_cnt = r_cnt + t_waddr'(1);
                    if (r_cnt == LAST_WORD) n_iss = 1'b0;
                end
                if (r_dv) begin
                    if (srch_res.hit) begin
                        // run found: sweep it reserved
                        n_dv       = 1'b0;
                        n_iss      = 1'b1;
                        n_cnt      = srch_res.start[FRAME_BITS-1:WORD_IDX_BITS];
                        n_lo       = {1'b0, srch_res.start};
                        n_hi       = {1'b0, srch_res.start} + r_cfg.want;
                        n_set      = 1'b1;
                        n_res_addr = {srch_res.start, PAGE_SHIFT'(0)};
                        n_state    = S_APPLY;
                    end else begin
                        n_run = srch_res.run_next;
                        if (r_dw == LAST_WORD) begin
                            n_status = STATUS_NO_RUN;
                            n_state  = S_FIN;
                        end
                    end
                end
            end
            S_APPLY: begin
                // read, modify, write one word a cycle; count its changes in the cycle after its write
                n_dv = r_iss;
                n_dw = r_cnt;
                if (r_iss) begin
                    if (r_cnt == last_w) n_iss = 1'b0;
                    else n_cnt = r_cnt + t_waddr'(1);
                end
                if (r_dv) ram_we = 1'b1;
                n_chg = apply_chg;
                n_cv  = r_dv;
                if (r_cv) begin
                    n_free = r_set ? r_free - t_cnt'(pop_count(r_chg))
                                   : r_free + t_cnt'(pop_count(r_chg));
                end
                if (!r_iss && !r_dv && !r_cv) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || i_ready) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output register
        if (load) n_ov = 1'b1;
        else if (r_ov && i_ready) n_ov = 1'b0;
        else n_ov = r_ov;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_iss   <= 1'b0;
            r_dv    <= 1'b0;
            r_cv    <= 1'b0;
            r_ov    <= 1'b0;
            r_free  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_iss   <= n_iss;
            r_dv    <= n_dv;
            r_cv    <= n_cv;
            r_ov    <= n_ov;
            r_free  <= n_free;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_type     <= n_type;
        r_base     <= n_base;
        r_len      <= n_len;
        r_fcnt     <= n_fcnt;
        r_cnt      <= n_cnt;
        r_dw       <= n_dw;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_set      <= n_set;
        r_run      <= n_run;
        r_cfg      <= n_cfg;
        r_chg      <= n_chg;
        r_status   <= n_status;
        r_res_addr <= n_res_addr;
        if (load) begin
            r_o_status <= r_status;
            r_o_addr   <= r_res_addr;
            r_o_free   <= r_free;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ov;
    assign o_status      = r_o_status;
    assign o_result_addr = r_o_addr;
    assign o_free_count  = r_o_free;

`ifndef NO_ASSERTIONS
    // one request at a time: after a transfer in, the block is busy
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after a request transfer");

    // sweep never writes the word it is reading in the same cycle
    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_iss && r_state == S_APPLY) |-> (ram_waddr != r_cnt))
        else $error("bitmap write and read collide during sweep");

    // change counting only happens inside a sweep
    a_count_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv |-> (r_state == S_APPLY))
        else $error("change mask pending outside sweep");

    // free count never exceeds the window
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= t_cnt'(NUM_FRAMES))
        else $error("free count out of range");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bitmap frame allocator
// Drives alloc, free, release and reserve requests through the valid/ready
// request channel and predicts each result from a bit-per-frame shadow map
// and its own free count. Results are checked field by field in order.
// Runs a directed sweep of corner cases, then random traffic under several
// idle and stall patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import bfa_pkg::*;

    localparam longint unsigned WIN_END   = longint'(WINDOW_BYTES);
    localparam int              CYCLE_CAP = 6_000_000;
    localparam int              PHASE_LEN = 138;

    typedef struct {
        t_req  kind;
        t_addr base;
        t_addr len;
        t_cnt  count;
    } alloc_req_t;

    typedef struct packed {
        logic      status;
        t_res_addr addr;
        t_cnt      free_cnt;
    } alloc_result_t;

    typedef struct {
        int unsigned start;
        int unsigned count;
    } frame_run_t;

    // Shadow of the frame map and free count; holds results still owed
    class alloc_scoreboard;
        bit            fmap[NUM_FRAMES];
        int unsigned   free_frames;
        alloc_result_t pending[$];
        int            errors;

        function new();
            foreach (fmap[i]) fmap[i] = 1'b1;
            free_frames = 0;
            errors      = 0;
        endfunction

        // set one frame, keeping the free count exact
        function void put_frame(longint unsigned f, bit rsv);
            if (f >= NUM_FRAMES) return;
            if (fmap[f] == rsv) return;
            fmap[f] = rsv;
            if (rsv) free_frames--;
            else free_frames++;
        endfunction

        // byte range clamped to the window, rounded inward to whole frames
        function void mark_range(longint unsigned b, longint unsigned len, bit rsv);
            longint unsigned stop_byte, lo, hi, f;
            if (b >= WIN_END) return;
            stop_byte = b + len;
            if (stop_byte > WIN_END) stop_byte = WIN_END;
            lo = (b + PAGE_BYTES - 1) >> PAGE_SHIFT;
            hi = stop_byte >> PAGE_SHIFT;
            for (f = lo; f < hi; f++) put_frame(f, rsv);
        endfunction

        // predict the outcome of an accepted request and queue it
        function alloc_result_t note_request(alloc_req_t r);
            alloc_result_t   res;
            longint unsigned want, run, f, start, first;
            bit              found;
            res.status = STATUS_OK;
            res.addr   = '0;
            case (r.kind)
                REQ_ALLOC: begin
                    want  = (r.count == 0) ? 1 : r.count;
                    run   = 0;
                    start = 0;
                    found = 1'b0;
                    for (f = 0; f < NUM_FRAMES; f++) begin
                        if (fmap[f]) begin
                            run = 0;
                        end else begin
                            run++;
                            if (run == want) begin
                                start = f + 1 - want;
                                found = 1'b1;
                                break;
                            end
                        end
                    end
                    if (found) begin
                        for (f = start; f < start + want; f++) put_frame(f, 1'b1);
                        res.addr = t_res_addr'(start << PAGE_SHIFT);
                    end else begin
                        res.status = STATUS_NO_RUN;
                    end
                end
                REQ_FREE: begin
                    first = r.base >> PAGE_SHIFT;
                    for (f = 0; f < r.count; f++) begin
                        if (first + f >= NUM_FRAMES) break;
                        put_frame(first + f, 1'b0);
                    end
                end
                REQ_RELEASE: mark_range(r.base, r.len, 1'b0);
                default:     mark_range(r.base, r.len, 1'b1);
            endcase
            res.free_cnt = t_cnt'(free_frames);
            pending.push_back(res);
            return res;
        endfunction

        // compare one returned result with the oldest prediction
        function void check_result(logic st, t_res_addr addr, t_cnt cnt);
            alloc_result_t exp_res;
            if (pending.size() == 0) begin
                $error("result with nothing outstanding: status %0d addr 0x%0h free %0d",
                       st, addr, cnt);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (st !== exp_res.status) begin
                $error("status mismatch: expected %0d, got %0d", exp_res.status, st);
                errors++;
            end
            if (addr !== exp_res.addr) begin
                $error("result_addr mismatch: expected 0x%0h, got 0x%0h", exp_res.addr, addr);
                errors++;
            end
            if (cnt !== exp_res.free_cnt) begin
                $error("free_count mismatch: expected %0d, got %0d", exp_res.free_cnt, cnt);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_req      i_req_type;
    t_addr     i_base_addr;
    t_addr     i_length;
    t_cnt      i_frame_count;
    logic      o_valid;
    logic      i_ready;
    logic      o_status;
    t_res_addr o_result_addr;
    t_cnt      o_free_count;

    alloc_scoreboard sb = new();
    frame_run_t      live_runs[$];
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              hold_len       = 0;
    int              cycles         = 0;

    bitmap_frame_allocator_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_base_addr   (i_base_addr),
        .i_length      (i_length),
        .i_frame_count (i_frame_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_result_addr (o_result_addr),
        .o_free_count  (o_free_count)
    );

    always #4 i_clk = ~i_clk;

    // run-length guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_status, o_result_addr, o_free_count);
        end
    end

    // result-side ready: random stalls plus an optional long hold-off
    initial begin : ready_driver
        int held;
        held    = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len != 0) begin
                held     = hold_len;
                hold_len = 0;
            end
            if (held != 0) begin
                i_ready <= 1'b0;
                held--;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic alloc_req_t mk_req(t_req k, t_addr b, t_addr l, t_cnt c);
        alloc_req_t r;
        r.kind  = k;
        r.base  = b;
        r.len   = l;
        r.count = c;
        return r;
    endfunction

    // offer one request and wait for its transfer
    task automatic send_request(input alloc_req_t r);
        alloc_result_t res;
        frame_run_t    run;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= r.kind;
        i_base_addr   <= r.base;
        i_length      <= r.len;
        i_frame_count <= r.count;
        do @(posedge i_clk); while (!o_ready);
        res = sb.note_request(r);
        if (r.kind == REQ_ALLOC && res.status == STATUS_OK) begin
            run.start = res.addr >> PAGE_SHIFT;
            run.count = (r.count == 0) ? 1 : r.count;
            live_runs.push_back(run);
        end
    endtask

    // small in-window byte range, aligned or not
    function automatic alloc_req_t range_req(t_req k, int unsigned max_frames);
        t_addr b, l;
        b = t_addr'($urandom_range(WINDOW_BYTES - 1));
        if ($urandom_range(1)) b[PAGE_SHIFT-1:0] = '0;
        l = t_addr'($urandom_range(max_frames)) << PAGE_SHIFT;
        if ($urandom_range(1)) l = l + t_addr'($urandom_range(PAGE_BYTES - 1));
        return mk_req(k, b, l, '0);
    endfunction

    // mostly well-formed traffic: allocs, frees of live runs, small ranges
    function automatic alloc_req_t pick_request();
        alloc_req_t  r;
        frame_run_t  run;
        int unsigned sel, idx;
        t_addr       b;
        sel = $urandom_range(99);
        if (sb.free_frames < 512 && sel >= 12 && sel < 70) sel = 70;
        if (sel < 12) begin
            // noise over the whole field ranges
            b = $urandom_range(1) ? t_addr'({$urandom, $urandom})
                                  : t_addr'($urandom_range(WINDOW_BYTES - 1));
            r = mk_req(t_req'($urandom_range(3)), b, t_addr'({$urandom, $urandom}),
                       t_cnt'($urandom_range(NUM_FRAMES)));
        end else if (sel < 40) begin
            r = mk_req(REQ_ALLOC, '0, '0,
                       t_cnt'(($urandom_range(9) == 0) ? $urandom_range(400)
                                                         : $urandom_range(16)));
        end else if (sel < 62 && live_runs.size() != 0) begin
            idx = $urandom_range(live_runs.size() - 1);
            run = live_runs[idx];
            live_runs.delete(idx);
            b = (t_addr'(run.start) << PAGE_SHIFT) | t_addr'($urandom_range(PAGE_BYTES - 1));
            r = mk_req(REQ_FREE, b, '0,
                       t_cnt'(($urandom_range(3) == 0) ? $urandom_range(run.count)
                                                         : run.count));
        end else if (sel < 88) begin
            r = range_req(REQ_RELEASE, 300);
        end else begin
            r = range_req(REQ_RESERVE, 40);
        end
        return r;
    endfunction

    // stimulus and end of run
    initial begin : main_seq
        alloc_req_t dir_reqs[$];
        int         send_pct[4];
        int         recv_pct[4];
        send_pct = '{0, 72, 0, 6};
        recv_pct = '{0, 0, 72, 6};

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_req_type    = REQ_ALLOC;
        i_base_addr   = '0;
        i_length      = '0;
        i_frame_count = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases
        dir_reqs.push_back(mk_req(REQ_ALLOC, '0, '0, 17'd1));          // nothing free yet
        dir_reqs.push_back(mk_req(REQ_FREE, 40'd0, '0, 17'd4));
        dir_reqs.push_back(mk_req(REQ_RELEASE, 40'd0, 40'd4095, '0));  // ends inside frame 0
        dir_reqs.push_back(mk_req(REQ_RELEASE, 40'd1, 40'h3_0000, '0)); // unaligned start
        dir_reqs.push_back(mk_req(REQ_RELEASE, 40'd0, '1, '0));        // whole window
        dir_reqs.push_back(mk_req(REQ_ALLOC, '0, '0, 17'd0));          // zero means one
        dir_reqs.push_back(mk_req(REQ_ALLOC, '0, '0, 17'd65536));      // too big now
        dir_reqs.push_back(mk_req(REQ_FREE, 40'h123, '0, 17'd1));      // unaligned free
        dir_reqs.push_back(mk_req(REQ_ALLOC, '0, '0, 17'd65536));      // takes everything
        dir_reqs.push_back(mk_req(REQ_RELEASE, t_addr'(WINDOW_BYTES), 40'h10_0000, '0));
        dir_reqs.push_back(mk_req(REQ_RELEASE, '1, '1, '0));
        dir_reqs.push_back(mk_req(REQ_RELEASE, t_addr'(WINDOW_BYTES - PAGE_BYTES), '1, '0));
        dir_reqs.push_back(mk_req(REQ_FREE, '1, '0, 17'd65536));       // all past the window
        dir_reqs.push_back(mk_req(REQ_FREE, t_addr'(WINDOW_BYTES - 2 * PAGE_BYTES + 123),
                                  '0, 17'd5));                          // runs off the end
        dir_reqs.push_back(mk_req(REQ_FREE, 40'h5000, '0, 17'd0));     // zero frames
        dir_reqs.push_back(mk_req(REQ_FREE, 40'h5000, '0, 17'd2));
        dir_reqs.push_back(mk_req(REQ_FREE, 40'h5000, '0, 17'd2));     // already free
        dir_reqs.push_back(mk_req(REQ_RESERVE, 40'd0, '1, '0));        // reserve all
        dir_reqs.push_back(mk_req(REQ_RELEASE, 40'h1234, 40'h1_0000, '0));
        dir_reqs.push_back(mk_req(REQ_RELEASE, 40'h2_0000, 40'h10_0000, '0));
        dir_reqs.push_back(mk_req(REQ_RESERVE, 40'h4000, 40'h2_0000, '0)); // partly reserved
        dir_reqs.push_back(mk_req(REQ_ALLOC, '0, '0, 17'd3));
        dir_reqs.push_back(mk_req(REQ_ALLOC, '0, '0, 17'd64));
        dir_reqs.push_back(mk_req(REQ_ALLOC, '0, '0, 17'd65));         // spans a word border
        foreach (dir_reqs[i]) send_request(dir_reqs[i]);

        // random traffic across idle/stall patterns
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            repeat (PHASE_LEN) send_request(pick_request());
            if (ph == 0) begin
                // long receiver hold-off while requests keep coming
                hold_len = 3000;
                repeat (12) begin
                    send_request(mk_req(REQ_FREE, t_addr'($urandom_range(WINDOW_BYTES - 1)),
                                        '0, t_cnt'($urandom_range(8))));
                end
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bfa_pkg.sv
hdl/bfa_ram.sv
hdl/bfa_search_unit.sv
hdl/bitmap_frame_allocator_top.sv
tb/tb_top.sv
